/* src/icu_pkg.sv */
// ----------------------------------------------------------------------------
// icu_pkg: shared types and constants of the inversion counter
// Sizes of the cell chain, the request token that travels along it, and the
// mapping of a signed value onto an unsigned ordering key.
// ----------------------------------------------------------------------------
package icu_pkg;

  // Number of cells in the chain, one stored value each.
  localparam int MAX_ITEMS  = 1024;
  // Width at which values are compared.
  localparam int VALUE_BITS = 32;
  // Width of the incoming value port.
  localparam int IN_W       = 32;
  // Width of the inversion count result.
  localparam int OUT_W      = 19;

  // Cell index, element counter and per-request greater count widths.
  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int GT_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  // Running total sum width: one bit of headroom over the saturation limit.
  localparam int SUM_W = OUT_W + 1;

  localparam logic [OUT_W-1:0] TOTAL_MAX = {OUT_W{1'b1}};

  // One request moving down the chain.
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic                  ovf;      // arrived with the store full
    logic [IDX_W-1:0]      index;    // position in the sequence, its cell
    logic [VALUE_BITS-1:0] key;
    logic [GT_W-1:0]       greater;  // earlier values found greater so far
  } token_t;

  // Sign-extend, cut to VALUE_BITS and flip the sign bit, so that an
  // unsigned compare of keys follows the signed order of the values.
  function automatic logic [VALUE_BITS-1:0] order_key(input logic [IN_W-1:0] raw);
    logic [VALUE_BITS+IN_W-1:0] ext;
    logic [VALUE_BITS-1:0]      cut;
    ext = {{VALUE_BITS{raw[IN_W-1]}}, raw};
    cut = ext[VALUE_BITS-1:0];
    return {~cut[VALUE_BITS-1], cut[VALUE_BITS-2:0]};
  endfunction

endpackage

/* src/icu_cell.sv */
// ----------------------------------------------------------------------------
// icu_cell: one cell of the inversion counter chain
// Holds one stored key, compares it with the passing request and forwards the
// request to the next cell. The request whose index equals the cell's slot
// writes its key here.
// ----------------------------------------------------------------------------
module icu_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [icu_pkg::IDX_W-1:0]  slot,
  input  icu_pkg::token_t            tok_in,
  output icu_pkg::token_t            tok_out
);
  import icu_pkg::*;

  logic [VALUE_BITS-1:0] stored;
  token_t                tok_next;
  logic                  live;

  // A request compares only against cells filled earlier in its sequence.
  always_comb begin
    live     = tok_in.valid && !tok_in.ovf;
    tok_next = tok_in;
    if (live && (slot < tok_in.index) && (stored > tok_in.key)) begin
      tok_next.greater = tok_in.greater + GT_W'(1);
    end
  end

  // Pass the request on; only the valid flag is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

  // Store the key of the request that owns this slot.
  always_ff @(posedge clk) begin
    if (advance && live && (tok_in.index == slot)) begin
      stored <= tok_in.key;
    end
  end

endmodule

/* src/icu_tail.sv */
// ----------------------------------------------------------------------------
// icu_tail: running total and result register
// Adds the greater count of each request leaving the chain to the running
// total with saturation, and on the final request of a sequence loads the
// result register and clears the total. Decides when the chain may move.
// ----------------------------------------------------------------------------
module icu_tail (
  input  logic                       clk,
  input  logic                       rst,
  input  icu_pkg::token_t            tok,
  input  logic                       result_stall,
  output logic                       advance,
  output logic                       result_valid,
  output logic [icu_pkg::OUT_W-1:0]  inversions,
  output logic                       overflow
);
  import icu_pkg::*;

  logic [OUT_W-1:0] total;
  logic             ovf;
  logic [SUM_W-1:0] sum;
  logic [OUT_W-1:0] total_next;
  logic             ovf_next;
  logic             produces;

  // The chain holds only when a new result meets a stalled, full register.
  always_comb begin
    produces = tok.valid && tok.last;
    advance  = !(result_valid && result_stall) || !produces;
  end

  // Saturating accumulation; requests that found the store full add nothing.
  always_comb begin
    sum      = SUM_W'(total) + SUM_W'(tok.greater);
    ovf_next = ovf || tok.ovf;
    if (tok.ovf) begin
      total_next = total;
    end else if (sum > SUM_W'(TOTAL_MAX)) begin
      total_next = TOTAL_MAX;
    end else begin
      total_next = sum[OUT_W-1:0];
    end
  end

  // Running total and overflow flag of the current sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      ovf   <= 1'b0;
    end else if (advance && tok.valid) begin
      if (tok.last) begin
        total <= '0;
        ovf   <= 1'b0;
      end else begin
        total <= total_next;
        ovf   <= ovf_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (advance && produces) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produces) begin
      inversions <= total_next;
      overflow   <= ovf_next;
    end
  end

`ifndef SYNTH
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TOTAL_MAX)
    else $error("running total above saturation limit");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    advance && produces |=> result_valid)
    else $error("final request did not load the result register");

  a_total_clear: assert property (@(posedge clk) disable iff (rst)
    advance && produces |=> (total == '0) && !ovf)
    else $error("running total not cleared after a result");
`endif

endmodule

/* src/inversion_counter_unit.sv */
// The result of a sequence is registered by the tail after its final value has passed all MAX_ITEMS cells.
// Throughput: one value per cycle while the chain advances; each value walks the chain of MAX_ITEMS cells.
// The chain holds only while a new result waits on a stalled, full result register.
// Reset clears the element count, running total, overflow flag and all valid
// flags; stored values need no clearing since only slots written earlier are read.
// ----------------------------------------------------------------------------
// inversion_counter_unit: streaming inversion counter
// Counts pairs of earlier values strictly greater than later ones in a
// sequence, using a systolic chain of compare cells and a tail accumulator.
// ----------------------------------------------------------------------------
module inversion_counter_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [icu_pkg::IN_W-1:0]   value,
  input  logic                       last,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [icu_pkg::OUT_W-1:0]  inversions,
  output logic                       overflow
);
  import icu_pkg::*;

  token_t           chain [0:MAX_ITEMS];
  logic [CNT_W-1:0] count;
  logic             has_room;
  logic             accept;
  logic             advance;

  assign item_stall = !advance;
  assign accept     = item_valid && advance;
  assign has_room   = count < CNT_W'(MAX_ITEMS);

  // Build the request that enters the first cell.
  always_comb begin
    chain[0].valid   = accept;
    chain[0].last    = last;
    chain[0].ovf     = !has_room;
    chain[0].index   = count[IDX_W-1:0];
    chain[0].key     = order_key(value);
    chain[0].greater = '0;
  end

  // Element count of the current sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (last) begin
        count <= '0;
      end else if (has_room) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Chain of compare cells.
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    icu_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .slot    (IDX_W'(k)),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  icu_tail u_tail (
    .clk          (clk),
    .rst          (rst),
    .tok          (chain[MAX_ITEMS]),
    .result_stall (result_stall),
    .advance      (advance),
    .result_valid (result_valid),
    .inversions   (inversions),
    .overflow     (overflow)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("element count above store size");

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> count == '0)
    else $error("element count not cleared after final value");

  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(chain[1].valid))
    else $error("first cell moved while the chain was held");
`endif

endmodule
